/* sv/lps_pkg.sv */
// Shared types, constants and tables of the LED pattern sequencer.
package lps_pkg;

    // Sizing
    localparam int NUM_BANKS  = 4;
    localparam int MAX_STEPS  = 16;
    localparam int PATS_PER_BANK = 4;
    localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int PAT_IDX_W  = 2;
    localparam int STEP_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int LEN_W      = $clog2(MAX_STEPS + 1);
    localparam int SLOT_W     = BANK_W + PAT_IDX_W;
    localparam int NUM_SLOTS  = 1 << SLOT_W;
    localparam int MEM_AW     = SLOT_W + STEP_W;
    localparam int MEM_DEPTH  = 1 << MEM_AW;

    // Field widths fixed by the interface
    localparam int REQ_W      = 2;
    localparam int AMOUNT_W   = 8;
    localparam int STATUS_W   = 3;
    localparam int WR_BANK_W  = 2;
    localparam int WR_STEP_W  = 4;
    localparam int LED_W      = 8;
    localparam int WR_LEN_W   = 5;
    localparam int DELAY_W    = 16;
    localparam int PIN_W      = 16;
    localparam int ABANK_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Queue depths
    localparam int CQ_DEPTH   = 4;
    localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);
    localparam int RQ_DEPTH   = 4;
    localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W   = $clog2(RQ_DEPTH + 1);

    // Countdown reload while no pattern plays
    localparam logic [DELAY_W-1:0] IDLE_RELOAD = DELAY_W'(100);

    // Pin remap of an emitted value
    localparam logic [PIN_W-1:0] PIN_LOW_MASK = PIN_W'(16'h0003);
    localparam int               PIN_LOW_POS  = 14;
    localparam logic [PIN_W-1:0] PIN_USED     = PIN_W'(16'hC03F);
    localparam logic [PIN_W-1:0] PIN_FREE     = PIN_W'(16'h3FF0) & ~PIN_USED;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MASK    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANK = CFG_IDX_W'(1);

    // Status codes of a status item; codes above lockup mean off
    localparam logic [STATUS_W-1:0] ST_SLEEP   = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_STANDBY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_ON      = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_CLASH   = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_LOCKUP  = STATUS_W'(4);

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_STATUS = 2'd1,
        REQ_STEP   = 2'd2,
        REQ_HEADER = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        PAT_STANDBY = 3'd0,
        PAT_ON      = 3'd1,
        PAT_CLASH   = 3'd2,
        PAT_LOCKUP  = 3'd3,
        PAT_NONE    = 3'd4
    } pat_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_STATUS,
        OP_STEP_WR,
        OP_HDR_WR
    } op_t;

    // Classified item carried from front to back
    typedef struct packed {
        op_t                   op;
        logic [AMOUNT_W-1:0]   amount;
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     wr_slot;
        logic [STEP_W-1:0]     wr_step;
        logic [LED_W-1:0]      wr_value;
        logic [LEN_W-1:0]      wr_length;
        logic [DELAY_W-1:0]    wr_delay;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } cq_wr_t;

    typedef struct packed {
        logic             push;
        logic [LED_W-1:0] led;
    } res_wr_t;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Remainder table: entry {s, m} holds s mod (m + 1)
    localparam int MOD_TAB_N = 1 << (2 * STEP_W);
    typedef logic [STEP_W-1:0] mod_tab_t [MOD_TAB_N];

    function automatic mod_tab_t build_mod_tab();
        mod_tab_t t;
        int       r;
        for (int s = 0; s < (1 << STEP_W); s++) begin
            for (int m = 0; m < (1 << STEP_W); m++) begin
                r = s;
                while (r > m) begin
                    r = r - (m + 1);
                end
                t[(s << STEP_W) | m] = STEP_W'(r);
            end
        end
        return t;
    endfunction

    localparam mod_tab_t MOD_TAB = build_mod_tab();

    // Map an emitted value onto the port bits
    function automatic logic [PIN_W-1:0] pin_map(input logic [LED_W-1:0] v);
        logic [PIN_W-1:0] w;
        w = ((PIN_W'(v) & PIN_LOW_MASK) << PIN_LOW_POS) | (PIN_W'(v) >> 2);
        return w & ~PIN_FREE;
    endfunction

endpackage

/* sv/lps_front.sv */
// Front end: accepts input items and classifies them into commands.
module lps_front (
    input  logic                            push,
    input  logic                            full,
    input  logic [lps_pkg::REQ_W-1:0]       req_type,
    input  logic [lps_pkg::AMOUNT_W-1:0]    tick_amount,
    input  logic [lps_pkg::STATUS_W-1:0]    new_status,
    input  logic [lps_pkg::WR_BANK_W-1:0]   wr_bank,
    input  logic [lps_pkg::PAT_IDX_W-1:0]   wr_pattern,
    input  logic [lps_pkg::WR_STEP_W-1:0]   wr_step,
    input  logic [lps_pkg::LED_W-1:0]       wr_value,
    input  logic [lps_pkg::WR_LEN_W-1:0]    wr_length,
    input  logic [lps_pkg::DELAY_W-1:0]     wr_delay,
    output lps_pkg::cq_wr_t                 cq_wr
);
    import lps_pkg::*;

    logic bank_ok;
    logic step_ok;

    // Range checks on write addresses
    assign bank_ok = (int'(wr_bank) < NUM_BANKS);
    assign step_ok = (int'(wr_step) < MAX_STEPS);

    // Decode the request and build the command
    always_comb
    begin
        cq_wr.push          = push && !full;
        cq_wr.cmd.amount    = tick_amount;
        cq_wr.cmd.status    = new_status;
        cq_wr.cmd.wr_slot   = {BANK_W'(wr_bank), wr_pattern};
        cq_wr.cmd.wr_step   = STEP_W'(wr_step);
        cq_wr.cmd.wr_value  = wr_value;
        cq_wr.cmd.wr_delay  = wr_delay;
        // saturate oversized lengths
        if (int'(wr_length) > MAX_STEPS)
        begin
            cq_wr.cmd.wr_length = LEN_W'(MAX_STEPS);
        end
        else
        begin
            cq_wr.cmd.wr_length = LEN_W'(wr_length);
        end
        case (req_t'(req_type))
            REQ_TICK:   cq_wr.cmd.op = OP_TICK;
            REQ_STATUS: cq_wr.cmd.op = OP_STATUS;
            REQ_STEP:   cq_wr.cmd.op = (bank_ok && step_ok) ? OP_STEP_WR : OP_NOP;
            REQ_HEADER: cq_wr.cmd.op = bank_ok ? OP_HDR_WR : OP_NOP;
            default:    cq_wr.cmd.op = OP_NOP;
        endcase
    end

endmodule

/* sv/lps_cmd_queue.sv */
// Command queue between the front end and the execution back end.
module lps_cmd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  lps_pkg::cq_wr_t  wr,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output lps_pkg::cmd_t    head
);
    import lps_pkg::*;

    cmd_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wptr_reg;
    logic [CQ_PTR_W-1:0] rptr_reg;
    logic [CQ_CNT_W-1:0] count_reg;
    logic [CQ_PTR_W-1:0] wptr_next;
    logic [CQ_PTR_W-1:0] rptr_next;
    logic [CQ_CNT_W-1:0] count_next;

    assign full  = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr.push)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Hold the queued commands
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            slot_reg[wptr_reg] <= wr.cmd;
        end
    end

endmodule

/* sv/lps_back.sv */
// Back end: pattern state, header tables, step memory and step playback.
module lps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lps_pkg::cfg_wr_t cfg,
    input  logic             cq_empty,
    input  lps_pkg::cmd_t    cq_head,
    input  logic             rq_room,
    output logic             cq_pop,
    output lps_pkg::res_wr_t res_wr
);
    import lps_pkg::*;

    // Configuration registers
    logic [LED_W-1:0]   mask_reg;
    logic [ABANK_W-1:0] abank_reg;

    // Pattern state
    pat_t               pat_reg,     pat_next;
    logic [BANK_W-1:0]  bank_reg,    bank_next;
    logic               loop_reg,    loop_next;
    logic [LEN_W-1:0]   step_reg,    step_next;
    logic [DELAY_W-1:0] count_reg,   count_next;
    logic               pending_reg, pending_next;

    // Header tables
    logic [LEN_W-1:0]   len_reg [NUM_SLOTS];
    logic [DELAY_W-1:0] dly_reg [NUM_SLOTS];

    // Step memory and its registered read
    logic [LED_W-1:0]   step_mem [MEM_DEPTH];
    logic [LED_W-1:0]   mem_q_reg;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_wa;
    logic [MEM_AW-1:0]  mem_ra;

    // Playback stage
    logic               r_valid_reg, r_valid_next;
    logic               r_zero_reg,  r_zero_next;

    logic [SLOT_W-1:0]  slot;
    logic [LEN_W-1:0]   len;
    logic [DELAY_W-1:0] dly;
    logic [DELAY_W-1:0] count_eff;
    logic [STEP_W-1:0]  len_m1;
    logic [STEP_W-1:0]  loop_idx;
    logic [LEN_W-1:0]   loop_inc;
    logic [BANK_W-1:0]  sel_bank;
    logic               fire;
    logic               exec;

    // Look up the current pattern
    always_comb
    begin
        slot      = {bank_reg, pat_reg[PAT_IDX_W-1:0]};
        len       = len_reg[slot];
        dly       = dly_reg[slot];
        count_eff = pending_reg ? dly : count_reg;
        len_m1    = STEP_W'(len - 1'b1);
        loop_idx  = MOD_TAB[{step_reg[STEP_W-1:0], len_m1}];
        loop_inc  = LEN_W'(loop_idx) + 1'b1;
        sel_bank  = BANK_W'(int'(abank_reg) % NUM_BANKS);
        fire      = (count_eff <= DELAY_W'(cq_head.amount));
        exec      = !cq_empty && ((cq_head.op != OP_TICK) || rq_room);
    end

    assign cq_pop = exec;

    // Execute the head command
    always_comb
    begin
        pat_next     = pat_reg;
        bank_next    = bank_reg;
        loop_next    = loop_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        mem_we       = 1'b0;
        mem_wa       = {cq_head.wr_slot, cq_head.wr_step};
        mem_ra       = {slot, step_reg[STEP_W-1:0]};
        r_valid_next = 1'b0;
        r_zero_next  = 1'b0;
        if (exec)
        begin
            count_next   = count_eff;
            pending_next = 1'b0;
            case (cq_head.op)
                OP_STATUS:
                begin
                    bank_next  = sel_bank;
                    step_next  = '0;
                    count_next = '0;
                    case (cq_head.status)
                        ST_SLEEP:   pat_next = PAT_NONE;
                        ST_STANDBY:
                        begin
                            pat_next  = PAT_STANDBY;
                            loop_next = 1'b1;
                        end
                        ST_ON:
                        begin
                            pat_next  = PAT_ON;
                            loop_next = 1'b1;
                        end
                        ST_CLASH:
                        begin
                            pat_next  = PAT_CLASH;
                            loop_next = 1'b0;
                        end
                        ST_LOCKUP:
                        begin
                            pat_next  = PAT_LOCKUP;
                            loop_next = 1'b1;
                        end
                        default:
                        begin
                            pat_next  = PAT_NONE;
                            loop_next = 1'b0;
                        end
                    endcase
                end
                OP_STEP_WR:
                begin
                    mem_we = 1'b1;
                end
                OP_TICK:
                begin
                    if (!fire)
                    begin
                        count_next = count_eff - DELAY_W'(cq_head.amount);
                    end
                    else if (pat_reg == PAT_NONE)
                    begin
                        // idle: emit zero and rearm
                        r_valid_next = 1'b1;
                        r_zero_next  = 1'b1;
                        count_next   = IDLE_RELOAD;
                    end
                    else if (!loop_reg)
                    begin
                        if (step_reg < len)
                        begin
                            r_valid_next = 1'b1;
                            step_next    = step_reg + 1'b1;
                            count_next   = dly;
                        end
                        else
                        begin
                            // one-shot done: switch to the on pattern, load its delay
                            pat_next     = PAT_ON;
                            bank_next    = sel_bank;
                            loop_next    = 1'b1;
                            step_next    = '0;
                            pending_next = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = dly;
                        mem_ra     = {slot, loop_idx};
                        if (len != '0)
                        begin
                            r_valid_next = 1'b1;
                            step_next    = (loop_inc >= len) ? '0 : loop_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Update state, configuration and header tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '1;
            abank_reg   <= '0;
            pat_reg     <= PAT_NONE;
            bank_reg    <= '0;
            loop_reg    <= 1'b0;
            step_reg    <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            r_zero_reg  <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                len_reg[i] <= '0;
                dly_reg[i] <= '0;
            end
        end
        else
        begin
            pat_reg     <= pat_next;
            bank_reg    <= bank_next;
            loop_reg    <= loop_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            r_valid_reg <= r_valid_next;
            r_zero_reg  <= r_zero_next;
            if (cfg.en)
            begin
                case (cfg.index)
                    CFG_LED_MASK:    mask_reg  <= LED_W'(cfg.data);
                    CFG_ACTIVE_BANK: abank_reg <= ABANK_W'(cfg.data);
                    default:
                    begin
                    end
                endcase
            end
            if (exec && (cq_head.op == OP_HDR_WR))
            begin
                len_reg[cq_head.wr_slot] <= cq_head.wr_length;
                dly_reg[cq_head.wr_slot] <= cq_head.wr_delay;
            end
        end
    end

    // Step memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            step_mem[mem_wa] <= cq_head.wr_value;
        end
        mem_q_reg <= step_mem[mem_ra];
    end

    // Mask the played step and hand it to the result queue
    always_comb
    begin
        res_wr.push = r_valid_reg;
        res_wr.led  = r_zero_reg ? '0 : (mem_q_reg & mask_reg);
    end

endmodule

/* sv/lps_res_queue.sv */
// Result queue that holds emitted LED values until they are popped.
module lps_res_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lps_pkg::res_wr_t            wr,
    input  logic                        pop,
    output logic                        empty,
    output logic                        full,
    output logic                        room,
    output logic [lps_pkg::LED_W-1:0]   head
);
    import lps_pkg::*;

    logic [LED_W-1:0]    slot_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wptr_reg;
    logic [RQ_PTR_W-1:0] rptr_reg;
    logic [RQ_CNT_W-1:0] count_reg;
    logic                do_pop;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == RQ_CNT_W'(RQ_DEPTH));
    // two free entries cover one step in flight plus a new one
    assign room   = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign head   = slot_reg[rptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr.push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr.push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!wr.push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold the queued results
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            slot_reg[wptr_reg] <= wr.led;
        end
    end

endmodule

/* sv/led_pattern_sequencer.sv */
// Top level of the LED pattern sequencer.
//
// Input items enter through a queue port: an item is taken at a clock edge
// with push high and full low. req_type selects tick, status change, step
// write or header write; the other fields are read as that type needs.
// Results leave through a queue port: led_value and pin_word show the oldest
// result while empty is low, and pop with empty low removes it. Only a tick
// that plays a step or fires while idle gives one; all other items give none.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 led_mask,
// 1 active_bank) at the clock edge; the user must write only while the block
// is idle, as the block does not enforce it. Items are taken one per cycle
// while full is low, and ticks wait for result queue room. An item passes a
// 4-entry command queue, the execute step and the registered step memory read.
// If pop stays low, the 4-entry result queue fills, ticks wait at the head of
// the command queue, and full rises once that queue holds 4 items; nothing
// is dropped. Reset empties both queues, clears the header tables, selects
// sleep and sets led_mask to 255; step memory is not cleared and a step must
// be written before it is played.
module led_pattern_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [lps_pkg::REQ_W-1:0]       req_type,
    input  logic [lps_pkg::AMOUNT_W-1:0]    tick_amount,
    input  logic [lps_pkg::STATUS_W-1:0]    new_status,
    input  logic [lps_pkg::WR_BANK_W-1:0]   wr_bank,
    input  logic [lps_pkg::PAT_IDX_W-1:0]   wr_pattern,
    input  logic [lps_pkg::WR_STEP_W-1:0]   wr_step,
    input  logic [lps_pkg::LED_W-1:0]       wr_value,
    input  logic [lps_pkg::WR_LEN_W-1:0]    wr_length,
    input  logic [lps_pkg::DELAY_W-1:0]     wr_delay,
    output logic                            empty,
    input  logic                            pop,
    output logic [lps_pkg::LED_W-1:0]       led_value,
    output logic [lps_pkg::PIN_W-1:0]       pin_word,
    input  logic                            cfg_wr_en,
    input  logic [lps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lps_pkg::*;

    cq_wr_t           cq_wr;
    cmd_t             cq_head;
    logic             cq_empty;
    logic             cq_pop;
    res_wr_t          res_wr;
    logic             rq_full;
    logic             rq_room;
    cfg_wr_t          cfg;
    logic [LED_W-1:0] rq_head;

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Classify incoming items
    lps_front u_front (
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .tick_amount (tick_amount),
        .new_status  (new_status),
        .wr_bank     (wr_bank),
        .wr_pattern  (wr_pattern),
        .wr_step     (wr_step),
        .wr_value    (wr_value),
        .wr_length   (wr_length),
        .wr_delay    (wr_delay),
        .cq_wr       (cq_wr)
    );

    // Decouple front and back
    lps_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cq_wr),
        .pop   (cq_pop),
        .full  (full),
        .empty (cq_empty),
        .head  (cq_head)
    );

    // Play patterns
    lps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cq_empty (cq_empty),
        .cq_head  (cq_head),
        .rq_room  (rq_room),
        .cq_pop   (cq_pop),
        .res_wr   (res_wr)
    );

    // Buffer results for the receiver
    lps_res_queue u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_wr),
        .pop   (pop),
        .empty (empty),
        .full  (rq_full),
        .room  (rq_room),
        .head  (rq_head)
    );

    assign led_value = rq_head;
    assign pin_word  = pin_map(rq_head);

    // A played step always finds a free result entry
    assert property (@(posedge clk) disable iff (!rst_n) res_wr.push |-> !rq_full)
        else $error("result queue overflow");

    // The back end only takes commands that are queued
    assert property (@(posedge clk) disable iff (!rst_n) cq_pop |-> !cq_empty)
        else $error("command taken from empty queue");

    // A taken transaction is queued for the back end
    assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> !cq_empty)
        else $error("accepted transaction lost");

    // A full result queue that is not popped offers no room
    assert property (@(posedge clk) disable iff (!rst_n)
        (rq_full && !pop) |=> !rq_room)
        else $error("result queue room flag wrong");

endmodule
